// ----- rtl/core/scancode_to_ascii_translator_defines.svh -----
// assertion macros used by the translator checker
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SC2A_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sc2a check failed");

// next-cycle implication, disabled during reset
`define SC2A_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sc2a check failed");

`endif

// ----- rtl/core/sc2a_pkg.sv -----
// types, scan code constants, key tables and translate function
package sc2a_pkg;

    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_ALT    = 8'h38;
    localparam logic [7:0] SC_CTRL   = 8'h1D;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] ALT_BIT   = 8'h80;

    localparam int MAIN_LEN = 58;
    localparam int CTRL_LEN = 51;

    localparam logic [7:0] TAB_PLAIN [0:MAIN_LEN-1] = '{
        8'h00,
        8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
        8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61,
        8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27,
        8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
        8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
    };

    localparam logic [7:0] TAB_SHIFT [0:MAIN_LEN-1] = '{
        8'h00,
        8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28,
        8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
        8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41,
        8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22,
        8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
        8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
    };

    localparam logic [7:0] TAB_CTRL [0:CTRL_LEN-1] = '{
        8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd31, 8'd0,  8'd8,  8'd9,  8'd17, 8'd23, 8'd5,  8'd18, 8'd20,
        8'd25, 8'd21, 8'd9,  8'd15, 8'd16, 8'd27, 8'd29, 8'd10, 8'd0,  8'd1,
        8'd19, 8'd4,  8'd6,  8'd7,  8'd8,  8'd10, 8'd11, 8'd12, 8'd0,  8'd0,
        8'd0,  8'd0,  8'd28, 8'd26, 8'd24, 8'd3,  8'd22, 8'd2,  8'd14, 8'd13
    };

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mod_flags_t;

    localparam int FLAGS_W = $bits(mod_flags_t);

    typedef struct packed {
        mod_flags_t flags;
        logic       char_valid;
        logic [7:0] char_code;
    } xlate_t;

    function automatic mod_flags_t set_mod(input mod_flags_t f, input logic [6:0] code,
                                           input logic value);
        mod_flags_t r;
        r = f;
        if (code == SC_LSHIFT[6:0] || code == SC_RSHIFT[6:0]) r.shift = value;
        if (code == SC_CAPS[6:0])  r.caps = value;
        if (code == SC_CTRL[6:0])  r.ctrl = value;
        if (code == SC_ALT[6:0])   r.alt  = value;
        return r;
    endfunction

    function automatic logic is_mod(input logic [7:0] code);
        return code == SC_LSHIFT || code == SC_RSHIFT || code == SC_CAPS ||
               code == SC_CTRL || code == SC_ALT;
    endfunction

    function automatic xlate_t translate(input mod_flags_t f, input logic [7:0] code);
        xlate_t r;
        r.flags      = f;
        r.char_valid = 1'b0;
        r.char_code  = 8'h00;
        if (code[7]) begin
            r.flags = set_mod(f, code[6:0], 1'b0);
        end else if (is_mod(code)) begin
            r.flags = set_mod(f, code[6:0], 1'b1);
        end else if (f.ctrl) begin
            if (code < 8'(CTRL_LEN)) begin
                r.char_valid = 1'b1;
                r.char_code  = TAB_CTRL[code[5:0]];
            end
        end else if (code < 8'(MAIN_LEN)) begin
            r.char_valid = 1'b1;
            r.char_code  = (f.shift ^ f.caps) ? TAB_SHIFT[code[5:0]] : TAB_PLAIN[code[5:0]];
        end
        // adding 0x80 modulo 256 flips the top bit
        if (r.char_valid && f.alt) r.char_code = r.char_code ^ ALT_BIT;
        return r;
    endfunction

endpackage

// ----- rtl/core/sc2a_ram.sv -----
// generic single-port-write, registered-read ram
module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/scancode_to_ascii_translator.sv -----
// top level: set-1 scan code to ascii translator with modifier state in ram
// path: an accepted code is registered in stage 1, then in the output register
// throughput: one code per cycle unless the output stalls, held by the
//   read-modify-write of the one-entry modifier ram, closed by a bypass register
// reset: synchronous active-low aresetn empties the pipe and marks the
//   modifier entry unwritten, so all modifiers read as not held
module scancode_to_ascii_translator
    import sc2a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_char_valid,
    output logic [7:0] m_char_code
);

    // pipeline control
    logic       s_accept;
    logic       s1_advance;
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_code_reg;

    // modifier state path
    logic       entry_valid_reg, entry_valid_next;
    logic       bypass_valid_reg, bypass_valid_next;
    mod_flags_t bypass_flags_reg;
    mod_flags_t ram_rd_flags;
    mod_flags_t cur_flags;
    xlate_t     xl;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_char_valid_reg;
    logic [7:0] out_char_code_reg;

    // stage 1 moves on when the output register is empty or being drained
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // state ram: read on accept, written back when stage 1 completes
    sc2a_ram #(
        .WIDTH (FLAGS_W),
        .DEPTH (1)
    ) u_mod_ram (
        .aclk    (aclk),
        .wr_en   (s1_advance),
        .wr_addr (1'b0),
        .wr_data (xl.flags),
        .rd_en   (s_accept),
        .rd_addr (1'b0),
        .rd_data (ram_rd_flags)
    );

    // pick newest modifiers: bypass for a write that raced the read,
    // not-held until the entry is first written
    always_comb begin
        if (bypass_valid_reg) begin
            cur_flags = bypass_flags_reg;
        end else if (entry_valid_reg) begin
            cur_flags = ram_rd_flags;
        end else begin
            cur_flags = '0;
        end
        xl = translate(cur_flags, s1_code_reg);
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end

        entry_valid_next = entry_valid_reg || s1_advance;

        // bypass is needed only by the code read in the same cycle as a write
        bypass_valid_next = bypass_valid_reg;
        if (s_accept || s1_advance) begin
            bypass_valid_next = s_accept && s1_advance;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            entry_valid_reg  <= 1'b0;
            bypass_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            entry_valid_reg  <= entry_valid_next;
            bypass_valid_reg <= bypass_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_code_reg <= s_scan_code;
        end
        if (s1_advance) begin
            bypass_flags_reg   <= xl.flags;
            out_char_valid_reg <= xl.char_valid;
            out_char_code_reg  <= xl.char_code;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_char_valid = out_char_valid_reg;
    assign m_char_code  = out_char_code_reg;

endmodule

// ----- rtl/core/sc2a_checker.sv -----
// port-level checker for the translator and its bind
`include "scancode_to_ascii_translator_defines.svh"

module sc2a_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_scan_code,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_char_valid,
    input logic [7:0] m_char_code
);

    // no-character beats carry a zero code
    `SC2A_ASSERT_NOW(a_nochar_zero, aclk, aresetn, m_valid && !m_char_valid, m_char_code == 8'h00)

    // an empty output register never back-pressures the input
    `SC2A_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // a stalled result beat holds
    `SC2A_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_char_valid) && $stable(m_char_code))

    // a waiting scan code beat holds
    `SC2A_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready,
                      s_valid && $stable(s_scan_code))

endmodule

bind scancode_to_ascii_translator sc2a_checker u_sc2a_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_scan_code  (s_scan_code),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_char_valid (m_char_valid),
    .m_char_code  (m_char_code)
);
